// ----- design/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared opcodes, result codes and controller/datapath interface types for
// the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

	// request opcodes (code 3 acts as check)
	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DESTROY = 2'd1;
	localparam logic [1:0] OP_CHECK   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch request, read both memories
		logic exec;       // register a result this cycle
		logic pop;        // create from the free stack
		logic fresh;      // create from the never-used region
		logic push;       // destroy: bump generation, push slot
		logic fail_full;  // create with no slot left
		logic fail_inv;   // destroy of a stale or invalid handle, or with no stack room
		logic check;      // validity query
	} gha_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       stack_nonempty;
		logic       stack_room;
		logic       hw_avail;
		logic       handle_ok;
	} gha_stat_t;

endpackage

// ----- design/gha_ctrl.sv -----
// ----------------------------------------------------------------------------
// gha_ctrl
// Two-state sequencer: accepts a request, then decides the action from the
// datapath status and issues it in the execute cycle.
// ----------------------------------------------------------------------------
module gha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gha_pkg::gha_stat_t stat,
	output gha_pkg::gha_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import gha_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic done_q;
	logic is_create;
	logic is_destroy;

	assign busy       = (state_q == S_EXEC);
	assign done       = done_q;
	assign is_create  = (stat.op == OP_CREATE);
	assign is_destroy = (stat.op == OP_DESTROY);

	always_comb begin
		cmd           = '0;
		cmd.capture   = start && (state_q == S_IDLE);
		cmd.exec      = (state_q == S_EXEC);
		if (state_q == S_EXEC) begin
			if (is_create) begin
				cmd.pop       = stat.stack_nonempty;
				cmd.fresh     = !stat.stack_nonempty && stat.hw_avail;
				cmd.fail_full = !stat.stack_nonempty && !stat.hw_avail;
			end else if (is_destroy) begin
				cmd.push     = stat.handle_ok && stat.stack_room;
				cmd.fail_inv = !(stat.handle_ok && stat.stack_room);
			end else begin
				cmd.check = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/gha_datapath.sv -----
// ----------------------------------------------------------------------------
// gha_datapath
// Generation memory, free stack memory, counters and result registers.
// The free stack holds slot numbers; its top entry is mirrored in a register
// so a create reads that slot's generation on the accepting edge.
// ----------------------------------------------------------------------------
module gha_datapath #(
	parameter int SLOTS     = 1024,
	parameter int GEN_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gha_pkg::gha_cmd_t  cmd,
	input  logic [1:0]        opcode,
	input  logic [9:0]        slot_index,
	input  logic [31:0]       generation,
	output gha_pkg::gha_stat_t stat,
	output logic [9:0]        out_slot,
	output logic [31:0]       out_generation,
	output logic              handle_valid,
	output logic [1:0]        status,
	output logic [9:0]        live_count
);
	import gha_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	logic [GEN_WIDTH-1:0] gen_mem [SLOTS];
	logic [SLOT_W-1:0]    stk_mem [SLOTS];

	logic [1:0]           op_q;
	logic [9:0]           slot_q;
	logic [31:0]          gen_q;
	logic [GEN_WIDTH-1:0] rd_gen_q;
	logic [SLOT_W-1:0]    rd_stk_q;
	logic [SLOT_W-1:0]    top_slot_q;

	logic [CNT_W-1:0]     free_top_q;
	logic [CNT_W-1:0]     high_water_q;
	logic [CNT_W-1:0]     live_q;
	logic [CNT_W-1:0]     live_nx;
	logic [CNT_W-1:0]     top_m1;
	logic [CNT_W-1:0]     top_m2;

	logic [31:0]          in_slot_ext;
	logic [31:0]          slot_ext;
	logic [31:0]          hw_ext;
	logic [31:0]          live_ext;
	logic [31:0]          pop_slot_ext;
	logic [SLOT_W-1:0]    rd_addr;
	logic [SLOT_W-1:0]    slot_addr;
	logic [SLOT_W-1:0]    hw_addr;
	logic [GEN_WIDTH-1:0] gen_inc;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	logic [GEN_WIDTH-1:0] wr_data;

	assign in_slot_ext  = 32'(slot_index);
	assign slot_ext     = 32'(slot_q);
	assign hw_ext       = 32'(high_water_q);
	assign pop_slot_ext = 32'(top_slot_q);
	// a create with a nonempty stack reads the generation of the slot it will pop
	assign rd_addr      = ((opcode == OP_CREATE) && (free_top_q != '0)) ? top_slot_q
	                      : in_slot_ext[SLOT_W-1:0];
	assign slot_addr    = slot_ext[SLOT_W-1:0];
	assign hw_addr      = hw_ext[SLOT_W-1:0];
	assign top_m1       = free_top_q - CNT_W'(1);
	assign top_m2       = free_top_q - CNT_W'(2);
	assign gen_inc      = rd_gen_q + GEN_WIDTH'(1);

	assign stat.op             = op_q;
	assign stat.stack_nonempty = (free_top_q != '0);
	assign stat.stack_room     = (free_top_q < CNT_W'(SLOTS));
	assign stat.hw_avail       = (high_water_q < CNT_W'(SLOTS));
	assign stat.handle_ok      = (slot_q != '0) && (slot_ext < hw_ext)
	                             && (32'(rd_gen_q) == gen_q);

	always_comb begin
		live_nx = live_q;
		if (cmd.pop || cmd.fresh) begin
			live_nx = live_q + CNT_W'(1);
		end else if (cmd.push && (live_q != '0)) begin
			live_nx = live_q - CNT_W'(1);
		end
	end
	assign live_ext = 32'(live_nx);

	// single write port on the generation memory
	assign wr_en   = cmd.fresh || cmd.push;
	assign wr_addr = cmd.fresh ? hw_addr : slot_addr;
	assign wr_data = cmd.fresh ? '0 : gen_inc;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_gen_q <= gen_mem[rd_addr];
			// entry under the top becomes the new top after a pop
			rd_stk_q <= stk_mem[top_m2[SLOT_W-1:0]];
		end
		if (wr_en) begin
			gen_mem[wr_addr] <= wr_data;
		end
		if (cmd.push) begin
			stk_mem[free_top_q[SLOT_W-1:0]] <= slot_addr;
			top_slot_q <= slot_addr;
		end else if (cmd.pop) begin
			top_slot_q <= rd_stk_q;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			slot_q <= slot_index;
			gen_q  <= generation;
		end
		if (cmd.exec) begin
			out_slot       <= slot_q;
			out_generation <= gen_q;
			handle_valid   <= cmd.pop || cmd.fresh || cmd.push
			                  || (cmd.check && stat.handle_ok);
			status         <= ST_OK;
			live_count     <= live_ext[9:0];
			if (cmd.pop) begin
				out_slot       <= pop_slot_ext[9:0];
				out_generation <= 32'(rd_gen_q);
			end else if (cmd.fresh) begin
				out_slot       <= hw_ext[9:0];
				out_generation <= '0;
			end else if (cmd.fail_full) begin
				status <= ST_FULL;
			end else if (cmd.fail_inv) begin
				status <= ST_INVALID;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q   <= '0;
			high_water_q <= CNT_W'(1);
			live_q       <= '0;
		end else begin
			live_q <= live_nx;
			if (cmd.pop) free_top_q <= top_m1;
			if (cmd.push) free_top_q <= free_top_q + CNT_W'(1);
			if (cmd.fresh) high_water_q <= high_water_q + CNT_W'(1);
		end
	end

endmodule

// ----- design/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot allocator with per-slot generation counters: create, destroy, check.
// ----------------------------------------------------------------------------
// For each request: raise start while busy is low; the item is
// taken on that edge, busy is high for the following cycle, and the result is
// presented on done for exactly one cycle after that. The receiver cannot
// stall; sample the result whenever done is high. A new start is accepted in
// the same cycle that done is high, so a new item is taken only once the last
// one is through. The pace is set by the generation memory, which is read
// once and written at most once per item: the accepting edge reads it (at the
// request's slot, or for a create at the slot on top of the free stack) along
// with the stack entry below the top, and the execute cycle compares and
// writes back. No clearing pass runs after reset; slots are handed out in
// order first, and only written entries ever affect a result.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
	parameter int SLOTS     = 1024,
	parameter int GEN_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [9:0]  slot_index,
	input  logic [31:0] generation,
	output logic        done,
	output logic [9:0]  out_slot,
	output logic [31:0] out_generation,
	output logic        handle_valid,
	output logic [1:0]  status,
	output logic [9:0]  live_count
);
	import gha_pkg::*;

	gha_cmd_t  cmd;
	gha_stat_t stat;

	// sequencer: idle / execute, plus the done strobe
	gha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// memories, counters and result registers
	gha_datapath #(
		.SLOTS     (SLOTS),
		.GEN_WIDTH (GEN_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.slot_index     (slot_index),
		.generation     (generation),
		.stat           (stat),
		.out_slot       (out_slot),
		.out_generation (out_generation),
		.handle_valid   (handle_valid),
		.status         (status),
		.live_count     (live_count)
	);

`ifndef SYNTHESIS
	// an accepted item is always followed by an execute cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && cmd.exec))
		else $error("accepted item did not enter execute");

	// done follows an execute cycle and nothing else
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.exec))
		else $error("done without a preceding execute cycle");

	// a failed request never reports a valid handle
	a_fail_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> !handle_valid)
		else $error("error status with handle_valid set");

	// at most one state-changing action per execute cycle
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $onehot0({cmd.pop, cmd.fresh, cmd.push}))
		else $error("conflicting allocator actions");
`endif

endmodule
